// ===== src/target_follow_velocity_controller_macros.svh =====
// Assertion macros for the target-follow velocity controller
`ifndef TARGET_FOLLOW_VELOCITY_CONTROLLER_MACROS_SVH
`define TARGET_FOLLOW_VELOCITY_CONTROLLER_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define TFVC_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TFVC_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/tfvc_pkg.sv =====
// Shared types, constants and microcode ROM of the target-follow controller
`timescale 1ns / 1ps

package tfvc_pkg;

  localparam int FRAC_BITS    = 12;
  localparam int AGE_BITS_DEF = 8;
  localparam int Q_W          = 16;
  localparam int GAIN_W       = 15;
  localparam int TIMEOUT_W    = 8;
  localparam int MODE_W       = 8;
  localparam int UPC_W        = 4;
  localparam int MUL_A_W      = 28;
  localparam int MUL_B_W      = 18;
  localparam int PROD_W       = MUL_A_W + MUL_B_W;
  localparam int URG_W        = FRAC_BITS + 1;

  localparam int Q_ONE       = 1 << FRAC_BITS;
  localparam int DIST_DB     = ((15 << FRAC_BITS) + 50) / 100;
  localparam int BEAR_DB     = ((5 << FRAC_BITS) + 50) / 100;
  localparam int VX_MIN      = -(((3 << FRAC_BITS) + 5) / 10);
  localparam int VX_STEP     = ((75 << FRAC_BITS) + 500) / 1000;
  localparam int YAW_STEP    = ((15 << FRAC_BITS) + 50) / 100;
  localparam int VX_OUT_DB   = ((8 << FRAC_BITS) + 50) / 100;
  localparam int YAW_OUT_DB  = ((10 << FRAC_BITS) + 50) / 100;
  localparam int EMA_ALPHA   = ((4 << FRAC_BITS) + 5) / 10;
  localparam int OFF_AXIS    = ((4 << FRAC_BITS) + 5) / 10;
  localparam int OFF_AXIS_VX = ((1 << FRAC_BITS) + 5) / 10;
  // urgency ramp spans exactly one unit: AVOID_ON - AVOID_FULL == Q_ONE
  localparam int AVOID_ON    = ((18 << FRAC_BITS) + 5) / 10;

  localparam logic [MODE_W-1:0] MODE_HALT_LO = 8'd5;
  localparam logic [MODE_W-1:0] MODE_HALT_HI = 8'd8;
  localparam logic [MODE_W-1:0] MODE_RECOVER = 8'd10;

  typedef logic [2:0] cfg_idx_t;
  localparam cfg_idx_t CFG_DESIRED_DISTANCE  = 3'd0;
  localparam cfg_idx_t CFG_DISTANCE_GAIN     = 3'd1;
  localparam cfg_idx_t CFG_YAW_GAIN          = 3'd2;
  localparam cfg_idx_t CFG_FORWARD_SPEED_MAX = 3'd3;
  localparam cfg_idx_t CFG_YAW_RATE_MAX      = 3'd4;
  localparam cfg_idx_t CFG_MIN_SAFE_DISTANCE = 3'd5;
  localparam cfg_idx_t CFG_AVOID_GAIN        = 3'd6;
  localparam cfg_idx_t CFG_TIMEOUT_TICKS     = 3'd7;

  typedef logic signed [Q_W-1:0] q_t;
  typedef logic [GAIN_W-1:0]     gain_t;
  typedef logic [UPC_W-1:0]      upc_t;

  typedef enum logic [1:0] {
    REQ_TICK  = 2'd0,
    REQ_SIGHT = 2'd1,
    REQ_MODE  = 2'd2,
    REQ_GAPS  = 2'd3
  } req_t;

  typedef struct packed {
    gain_t                desired_distance;
    gain_t                distance_gain;
    gain_t                yaw_gain;
    gain_t                forward_speed_max;
    gain_t                yaw_rate_max;
    gain_t                min_safe_distance;
    gain_t                avoid_gain;
    logic [TIMEOUT_W-1:0] timeout_ticks;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    desired_distance:  15'd6144,
    distance_gain:     15'd3277,
    yaw_gain:          15'd10240,
    forward_speed_max: 15'd3277,
    yaw_rate_max:      15'd4915,
    min_safe_distance: 15'd2458,
    avoid_gain:        15'd8192,
    timeout_ticks:     8'd10
  };

  typedef struct packed {
    logic [1:0]        req_type;
    q_t                bearing;
    q_t                distance;
    logic [MODE_W-1:0] robot_mode;
    gain_t             forward_clearance;
    gain_t             left_clearance;
    gain_t             right_clearance;
  } item_t;

  typedef struct packed {
    logic stop_request;
    q_t   forward_speed;
    q_t   yaw_rate;
  } res_t;

  typedef struct packed {
    logic stop;
    logic no_avoid;
    logic stale;
  } stat_t;

  typedef enum logic [2:0] {
    MA_NONE, MA_DG, MA_YG, MA_AG, MA_VMAX, MA_ALPHA, MA_PROD
  } mul_a_t;

  typedef enum logic [2:0] {
    MB_ZERO, MB_ERR, MB_SB, MB_URG, MB_SIDE, MB_URGC, MB_BDIFF, MB_DDIFF
  } mul_b_t;

  typedef enum logic [3:0] {
    ACT_NONE, ACT_VX, ACT_VY, ACT_BIAS, ACT_CAP, ACT_MOVE, ACT_STOP,
    ACT_SB, ACT_SD, ACT_LOAD, ACT_MODE, ACT_GAPS
  } act_t;

  typedef enum logic [1:0] {CS_NONE, CS_STOP, CS_NO_AVOID, CS_STALE} csel_t;

  typedef enum logic [1:0] {BR_NEXT, BR_COND, BR_END} br_t;

  typedef struct packed {
    mul_a_t ma;
    mul_b_t mb;
    act_t   act;
    csel_t  cs;
    br_t    br;
    logic   emit;
    upc_t   target;
  } cw_t;

  localparam upc_t UPC_TICK_CHECK = 4'd0;
  localparam upc_t UPC_TICK_VX    = 4'd1;
  localparam upc_t UPC_TICK_VY    = 4'd2;
  localparam upc_t UPC_TICK_AVOID = 4'd3;
  localparam upc_t UPC_TICK_BIAS  = 4'd4;
  localparam upc_t UPC_TICK_CAP   = 4'd5;
  localparam upc_t UPC_TICK_OUT   = 4'd6;
  localparam upc_t UPC_TICK_STOP  = 4'd7;
  localparam upc_t UPC_SIGHT_CHK  = 4'd8;
  localparam upc_t UPC_SIGHT_SB   = 4'd9;
  localparam upc_t UPC_SIGHT_SD   = 4'd10;
  localparam upc_t UPC_SIGHT_LOAD = 4'd11;
  localparam upc_t UPC_MODE       = 4'd12;
  localparam upc_t UPC_GAPS       = 4'd13;

  function automatic upc_t entry(input req_t r);
    upc_t a;
    unique case (r)
      REQ_TICK:  a = UPC_TICK_CHECK;
      REQ_SIGHT: a = UPC_SIGHT_CHK;
      REQ_MODE:  a = UPC_MODE;
      REQ_GAPS:  a = UPC_GAPS;
      default:   a = UPC_MODE;
    endcase
    return a;
  endfunction

  function automatic cw_t ucode(input upc_t a);
    cw_t w;
    w = '{ma: MA_NONE, mb: MB_ZERO, act: ACT_NONE, cs: CS_NONE, br: BR_END,
          emit: 1'b0, target: '0};
    unique case (a)
      UPC_TICK_CHECK: begin
        w.ma = MA_DG; w.mb = MB_ERR; w.cs = CS_STOP; w.br = BR_COND;
        w.target = UPC_TICK_STOP;
      end
      UPC_TICK_VX: begin
        w.ma = MA_YG; w.mb = MB_SB; w.act = ACT_VX; w.br = BR_NEXT;
      end
      UPC_TICK_VY: begin
        w.ma = MA_AG; w.mb = MB_URG; w.act = ACT_VY; w.br = BR_NEXT;
      end
      UPC_TICK_AVOID: begin
        w.ma = MA_PROD; w.mb = MB_SIDE; w.cs = CS_NO_AVOID; w.br = BR_COND;
        w.target = UPC_TICK_OUT;
      end
      UPC_TICK_BIAS: begin
        w.ma = MA_VMAX; w.mb = MB_URGC; w.act = ACT_BIAS; w.br = BR_NEXT;
      end
      UPC_TICK_CAP: begin
        w.act = ACT_CAP; w.br = BR_NEXT;
      end
      UPC_TICK_OUT: begin
        w.act = ACT_MOVE; w.emit = 1'b1;
      end
      UPC_TICK_STOP: begin
        w.act = ACT_STOP; w.emit = 1'b1;
      end
      UPC_SIGHT_CHK: begin
        w.ma = MA_ALPHA; w.mb = MB_BDIFF; w.cs = CS_STALE; w.br = BR_COND;
        w.target = UPC_SIGHT_LOAD;
      end
      UPC_SIGHT_SB: begin
        w.ma = MA_ALPHA; w.mb = MB_DDIFF; w.act = ACT_SB; w.br = BR_NEXT;
      end
      UPC_SIGHT_SD:   w.act = ACT_SD;
      UPC_SIGHT_LOAD: w.act = ACT_LOAD;
      UPC_MODE:       w.act = ACT_MODE;
      UPC_GAPS:       w.act = ACT_GAPS;
      default:        w.act = ACT_NONE;
    endcase
    return w;
  endfunction

endpackage

// ===== src/tfvc_datapath.sv =====
// Datapath: controller state, shared multiplier and per-step update logic
`timescale 1ns / 1ps

module tfvc_datapath #(
  parameter int AGE_BITS = tfvc_pkg::AGE_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            go,
  input  tfvc_pkg::cw_t   cw,
  input  tfvc_pkg::cfg_t  cfg,
  input  tfvc_pkg::item_t item,
  output tfvc_pkg::stat_t stat,
  output tfvc_pkg::res_t  res
);

  localparam int CMP_W  = (AGE_BITS > tfvc_pkg::TIMEOUT_W) ? AGE_BITS : tfvc_pkg::TIMEOUT_W;
  localparam int WIDE_W = 36;
  localparam int PW     = tfvc_pkg::PROD_W;
  localparam int FB     = tfvc_pkg::FRAC_BITS;

  typedef logic [AGE_BITS-1:0]     age_t;
  typedef logic [CMP_W-1:0]        cmp_t;
  typedef logic signed [WIDE_W-1:0] wide_t;
  typedef logic signed [PW-1:0]    prod_t;
  typedef logic [tfvc_pkg::URG_W-1:0] urg_t;

  localparam age_t  AGE_MAX = '1;
  localparam prod_t HALF12  = prod_t'(1) <<< (FB - 1);
  localparam prod_t HALF24  = prod_t'(1) <<< (2 * FB - 1);

  localparam wide_t W_ONE        = wide_t'(tfvc_pkg::Q_ONE);
  localparam wide_t W_DIST_DB    = wide_t'(tfvc_pkg::DIST_DB);
  localparam wide_t W_BEAR_DB    = wide_t'(tfvc_pkg::BEAR_DB);
  localparam wide_t W_VX_MIN     = wide_t'(tfvc_pkg::VX_MIN);
  localparam wide_t W_VX_STEP    = wide_t'(tfvc_pkg::VX_STEP);
  localparam wide_t W_YAW_STEP   = wide_t'(tfvc_pkg::YAW_STEP);
  localparam wide_t W_VX_OUT_DB  = wide_t'(tfvc_pkg::VX_OUT_DB);
  localparam wide_t W_YAW_OUT_DB = wide_t'(tfvc_pkg::YAW_OUT_DB);
  localparam wide_t W_OFF_AXIS   = wide_t'(tfvc_pkg::OFF_AXIS);
  localparam wide_t W_OFF_VX     = wide_t'(tfvc_pkg::OFF_AXIS_VX);
  localparam wide_t W_AVOID_ON   = wide_t'(tfvc_pkg::AVOID_ON);

  function automatic wide_t sx(input tfvc_pkg::q_t v);
    return wide_t'(v);
  endfunction

  function automatic wide_t ux(input tfvc_pkg::gain_t v);
    return wide_t'({1'b0, v});
  endfunction

  function automatic wide_t clamp(input wide_t v, input wide_t lo, input wide_t hi);
    wide_t r;
    if (v < lo) r = lo;
    else if (v > hi) r = hi;
    else r = v;
    return r;
  endfunction

  tfvc_pkg::q_t sb_r, sb_nxt, sd_r, sd_nxt;
  tfvc_pkg::q_t lf_r, lf_nxt, ly_r, ly_nxt;
  tfvc_pkg::q_t vx_r, vx_nxt, vy_r, vy_nxt;
  age_t         t_age_r, t_age_nxt, l_age_r, l_age_nxt;
  logic         t_seen_r, t_seen_nxt, l_seen_r, l_seen_nxt;
  logic [tfvc_pkg::MODE_W-1:0] mode_r, mode_nxt;
  tfvc_pkg::gain_t fg_r, fg_nxt, lg_r, lg_nxt, rg_r, rg_nxt;
  urg_t         urg_r, urg_nxt, urg_c;
  prod_t        prod_r, rs12, rs24;

  logic signed [tfvc_pkg::MUL_A_W-1:0] mul_a;
  logic signed [tfvc_pkg::MUL_B_W-1:0] mul_b;

  wide_t err_w, sb_w, sd_w, vx_w, vy_w, vmax_w, ymax_w, side_w, gap_d_w;
  wide_t r12_w, r24_w, q_w, mv_x, mv_y;
  logic  unsafe, fresh;
  age_t  t_age_inc, l_age_inc;

  always_comb begin
    sb_w    = sx(sb_r);
    sd_w    = sx(sd_r);
    vx_w    = sx(vx_r);
    vy_w    = sx(vy_r);
    vmax_w  = ux(cfg.forward_speed_max);
    ymax_w  = ux(cfg.yaw_rate_max);
    err_w   = sd_w - ux(cfg.desired_distance);
    side_w  = ux(rg_r) - ux(lg_r);
    gap_d_w = W_AVOID_ON - ux(fg_r);
    if (gap_d_w > W_ONE) urg_c = urg_t'(tfvc_pkg::Q_ONE);
    else if (gap_d_w < 0) urg_c = '0;
    else urg_c = gap_d_w[tfvc_pkg::URG_W-1:0];
    rs12  = (prod_r + HALF12) >>> FB;
    rs24  = (prod_r + HALF24) >>> (2 * FB);
    r12_w = wide_t'(rs12);
    r24_w = wide_t'(rs24);
  end

  always_comb begin
    case (mode_r) inside
      [tfvc_pkg::MODE_HALT_LO:tfvc_pkg::MODE_HALT_HI], tfvc_pkg::MODE_RECOVER: unsafe = 1'b1;
      default: unsafe = 1'b0;
    endcase
    stat.stale    = !t_seen_r || (cmp_t'(t_age_r) > cmp_t'(cfg.timeout_ticks));
    stat.stop     = unsafe || stat.stale;
    fresh         = l_seen_r && (cmp_t'(l_age_r) < cmp_t'(cfg.timeout_ticks));
    stat.no_avoid = !(fresh && (ux(fg_r) < W_AVOID_ON) && (vx_w > 0));
  end

  // operand selection for the shared multiplier
  always_comb begin
    case (cw.ma)
      tfvc_pkg::MA_DG:    mul_a = {{(tfvc_pkg::MUL_A_W - tfvc_pkg::GAIN_W){1'b0}}, cfg.distance_gain};
      tfvc_pkg::MA_YG:    mul_a = {{(tfvc_pkg::MUL_A_W - tfvc_pkg::GAIN_W){1'b0}}, cfg.yaw_gain};
      tfvc_pkg::MA_AG:    mul_a = {{(tfvc_pkg::MUL_A_W - tfvc_pkg::GAIN_W){1'b0}}, cfg.avoid_gain};
      tfvc_pkg::MA_VMAX:  mul_a = {{(tfvc_pkg::MUL_A_W - tfvc_pkg::GAIN_W){1'b0}},
                                   cfg.forward_speed_max};
      tfvc_pkg::MA_ALPHA: mul_a = tfvc_pkg::MUL_A_W'(tfvc_pkg::EMA_ALPHA);
      tfvc_pkg::MA_PROD:  mul_a = prod_r[tfvc_pkg::MUL_A_W-1:0];
      default:            mul_a = '0;
    endcase
    case (cw.mb)
      tfvc_pkg::MB_ERR:   mul_b = err_w[tfvc_pkg::MUL_B_W-1:0];
      tfvc_pkg::MB_SB:    mul_b = sb_w[tfvc_pkg::MUL_B_W-1:0];
      tfvc_pkg::MB_URG:   mul_b = {{(tfvc_pkg::MUL_B_W - tfvc_pkg::URG_W){1'b0}}, urg_c};
      tfvc_pkg::MB_SIDE:  mul_b = side_w[tfvc_pkg::MUL_B_W-1:0];
      tfvc_pkg::MB_URGC:  mul_b = {{(tfvc_pkg::MUL_B_W - tfvc_pkg::URG_W){1'b0}},
                                   urg_t'(tfvc_pkg::Q_ONE) - urg_r};
      tfvc_pkg::MB_BDIFF: mul_b = tfvc_pkg::MUL_B_W'(sx(item.bearing) - sb_w);
      tfvc_pkg::MB_DDIFF: mul_b = tfvc_pkg::MUL_B_W'(sx(item.distance) - sd_w);
      default:            mul_b = '0;
    endcase
  end

  // slew limit and output deadband for a move result
  always_comb begin
    mv_x = clamp(vx_w, sx(lf_r) - W_VX_STEP, sx(lf_r) + W_VX_STEP);
    if (mv_x < W_VX_OUT_DB && mv_x > -W_VX_OUT_DB) mv_x = '0;
    mv_y = clamp(vy_w, sx(ly_r) - W_YAW_STEP, sx(ly_r) + W_YAW_STEP);
    if (mv_y < W_YAW_OUT_DB && mv_y > -W_YAW_OUT_DB) mv_y = '0;
    res.stop_request  = (cw.act == tfvc_pkg::ACT_STOP);
    res.forward_speed = (cw.act == tfvc_pkg::ACT_MOVE) ? mv_x[tfvc_pkg::Q_W-1:0] : '0;
    res.yaw_rate      = (cw.act == tfvc_pkg::ACT_MOVE) ? mv_y[tfvc_pkg::Q_W-1:0] : '0;
  end

  always_comb begin
    t_age_inc  = (t_age_r == AGE_MAX) ? t_age_r : t_age_r + age_t'(1);
    l_age_inc  = (l_age_r == AGE_MAX) ? l_age_r : l_age_r + age_t'(1);
    sb_nxt     = sb_r;
    sd_nxt     = sd_r;
    lf_nxt     = lf_r;
    ly_nxt     = ly_r;
    vx_nxt     = vx_r;
    vy_nxt     = vy_r;
    t_age_nxt  = t_age_r;
    l_age_nxt  = l_age_r;
    t_seen_nxt = t_seen_r;
    l_seen_nxt = l_seen_r;
    mode_nxt   = mode_r;
    fg_nxt     = fg_r;
    lg_nxt     = lg_r;
    rg_nxt     = rg_r;
    urg_nxt    = urg_r;
    q_w        = '0;
    case (cw.act)
      tfvc_pkg::ACT_VX: begin
        q_w = clamp(r12_w, W_VX_MIN, vmax_w);
        if (!(err_w > W_DIST_DB || err_w < -W_DIST_DB)) q_w = '0;
        if (sd_w < ux(cfg.min_safe_distance) && q_w > 0) q_w = '0;
        vx_nxt = q_w[tfvc_pkg::Q_W-1:0];
      end
      tfvc_pkg::ACT_VY: begin
        q_w = clamp(-r12_w, -ymax_w, ymax_w);
        if (!(sb_w > W_BEAR_DB || sb_w < -W_BEAR_DB)) q_w = '0;
        vy_nxt = q_w[tfvc_pkg::Q_W-1:0];
        if ((sb_w > W_OFF_AXIS || sb_w < -W_OFF_AXIS) && vx_w > W_OFF_VX)
          vx_nxt = W_OFF_VX[tfvc_pkg::Q_W-1:0];
        urg_nxt = urg_c;
      end
      tfvc_pkg::ACT_BIAS: begin
        q_w    = clamp(vy_w - r24_w, -ymax_w, ymax_w);
        vy_nxt = q_w[tfvc_pkg::Q_W-1:0];
      end
      tfvc_pkg::ACT_CAP: begin
        if (vx_w > r12_w) vx_nxt = r12_w[tfvc_pkg::Q_W-1:0];
      end
      tfvc_pkg::ACT_MOVE: begin
        lf_nxt    = mv_x[tfvc_pkg::Q_W-1:0];
        ly_nxt    = mv_y[tfvc_pkg::Q_W-1:0];
        t_age_nxt = t_age_inc;
        l_age_nxt = l_age_inc;
      end
      tfvc_pkg::ACT_STOP: begin
        lf_nxt    = '0;
        ly_nxt    = '0;
        t_age_nxt = t_age_inc;
        l_age_nxt = l_age_inc;
      end
      tfvc_pkg::ACT_SB: begin
        q_w    = sb_w + r12_w;
        sb_nxt = q_w[tfvc_pkg::Q_W-1:0];
      end
      tfvc_pkg::ACT_SD: begin
        q_w        = sd_w + r12_w;
        sd_nxt     = q_w[tfvc_pkg::Q_W-1:0];
        t_age_nxt  = '0;
        t_seen_nxt = 1'b1;
      end
      tfvc_pkg::ACT_LOAD: begin
        sb_nxt     = item.bearing;
        sd_nxt     = item.distance;
        t_age_nxt  = '0;
        t_seen_nxt = 1'b1;
      end
      tfvc_pkg::ACT_MODE: mode_nxt = item.robot_mode;
      tfvc_pkg::ACT_GAPS: begin
        fg_nxt     = item.forward_clearance;
        lg_nxt     = item.left_clearance;
        rg_nxt     = item.right_clearance;
        l_age_nxt  = '0;
        l_seen_nxt = 1'b1;
      end
      default: q_w = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sb_r     <= '0;
      sd_r     <= '0;
      lf_r     <= '0;
      ly_r     <= '0;
      t_age_r  <= '0;
      l_age_r  <= '0;
      t_seen_r <= 1'b0;
      l_seen_r <= 1'b0;
      mode_r   <= '0;
      fg_r     <= '1;
      lg_r     <= '1;
      rg_r     <= '1;
    end else if (go) begin
      sb_r     <= sb_nxt;
      sd_r     <= sd_nxt;
      lf_r     <= lf_nxt;
      ly_r     <= ly_nxt;
      t_age_r  <= t_age_nxt;
      l_age_r  <= l_age_nxt;
      t_seen_r <= t_seen_nxt;
      l_seen_r <= l_seen_nxt;
      mode_r   <= mode_nxt;
      fg_r     <= fg_nxt;
      lg_r     <= lg_nxt;
      rg_r     <= rg_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      vx_r  <= vx_nxt;
      vy_r  <= vy_nxt;
      urg_r <= urg_nxt;
      if (cw.ma != tfvc_pkg::MA_NONE) prod_r <= PW'(mul_a * mul_b);
    end
  end

endmodule

// ===== src/target_follow_velocity_controller.sv =====
// Tick steps: check, speed, yaw, avoidance test, bias, cap, output; with no avoidance the test
// jumps to output; a stop goes from check to stop. A stale sighting loads, a fresh one smooths.
// One item in flight; a pending result is held, and the emit step waits, while out_stall is high.
// The item time is set by the microprogram length on the single shared multiplier.
// Reset: synchronous rst_n low loads default registers and clearances, clears ages, target, mode and out_valid.
`timescale 1ns / 1ps
`include "target_follow_velocity_controller_macros.svh"

module target_follow_velocity_controller #(
  parameter int AGE_BITS = tfvc_pkg::AGE_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  in_req_type,
  input  logic signed [15:0]          in_bearing,
  input  logic signed [15:0]          in_distance,
  input  logic [7:0]                  in_robot_mode,
  input  logic [14:0]                 in_forward_clearance,
  input  logic [14:0]                 in_left_clearance,
  input  logic [14:0]                 in_right_clearance,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_stop_request,
  output logic signed [15:0]          out_forward_speed,
  output logic signed [15:0]          out_yaw_rate,
  input  logic                        cfg_we,
  input  tfvc_pkg::cfg_idx_t          cfg_index,
  input  logic [14:0]                 cfg_wdata
);

  tfvc_pkg::cfg_t  cfg_r, cfg_nxt;
  tfvc_pkg::item_t item_r, item_nxt;
  tfvc_pkg::upc_t  pc_r, pc_nxt;
  tfvc_pkg::cw_t   cw;
  tfvc_pkg::stat_t stat;
  tfvc_pkg::res_t  res, out_res_r, out_res_nxt;
  logic            busy_r, busy_nxt, out_valid_r, out_valid_nxt;
  logic            in_acc, go, cond;

  assign cw       = tfvc_pkg::ucode(pc_r);
  assign in_stall = busy_r;
  assign in_acc   = in_valid && !busy_r;
  assign go       = busy_r && !(cw.emit && out_valid_r && out_stall);

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        tfvc_pkg::CFG_DESIRED_DISTANCE:  cfg_nxt.desired_distance  = cfg_wdata;
        tfvc_pkg::CFG_DISTANCE_GAIN:     cfg_nxt.distance_gain     = cfg_wdata;
        tfvc_pkg::CFG_YAW_GAIN:          cfg_nxt.yaw_gain          = cfg_wdata;
        tfvc_pkg::CFG_FORWARD_SPEED_MAX: cfg_nxt.forward_speed_max = cfg_wdata;
        tfvc_pkg::CFG_YAW_RATE_MAX:      cfg_nxt.yaw_rate_max      = cfg_wdata;
        tfvc_pkg::CFG_MIN_SAFE_DISTANCE: cfg_nxt.min_safe_distance = cfg_wdata;
        tfvc_pkg::CFG_AVOID_GAIN:        cfg_nxt.avoid_gain        = cfg_wdata;
        tfvc_pkg::CFG_TIMEOUT_TICKS:     cfg_nxt.timeout_ticks     = cfg_wdata[7:0];
        default:                         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (cw.cs)
      tfvc_pkg::CS_STOP:     cond = stat.stop;
      tfvc_pkg::CS_NO_AVOID: cond = stat.no_avoid;
      tfvc_pkg::CS_STALE:    cond = stat.stale;
      default:               cond = 1'b0;
    endcase
  end

  // step counter and branch
  always_comb begin
    busy_nxt = busy_r;
    pc_nxt   = pc_r;
    item_nxt = item_r;
    if (in_acc) begin
      item_nxt = '{req_type: in_req_type, bearing: in_bearing, distance: in_distance,
                   robot_mode: in_robot_mode, forward_clearance: in_forward_clearance,
                   left_clearance: in_left_clearance, right_clearance: in_right_clearance};
      pc_nxt   = tfvc_pkg::entry(tfvc_pkg::req_t'(in_req_type));
      busy_nxt = 1'b1;
    end else if (go) begin
      unique case (cw.br)
        tfvc_pkg::BR_NEXT: pc_nxt = pc_r + tfvc_pkg::upc_t'(1);
        tfvc_pkg::BR_COND: pc_nxt = cond ? cw.target : pc_r + tfvc_pkg::upc_t'(1);
        tfvc_pkg::BR_END:  busy_nxt = 1'b0;
        default:           busy_nxt = 1'b0;
      endcase
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    if (go && cw.emit) begin
      out_valid_nxt = 1'b1;
      out_res_nxt   = res;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r       <= tfvc_pkg::CFG_RESET;
      busy_r      <= 1'b0;
      pc_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cfg_r       <= cfg_nxt;
      busy_r      <= busy_nxt;
      pc_r        <= pc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r    <= item_nxt;
    out_res_r <= out_res_nxt;
  end

  tfvc_datapath #(
    .AGE_BITS (AGE_BITS)
  ) u_dp (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (go),
    .cw    (cw),
    .cfg   (cfg_r),
    .item  (item_r),
    .stat  (stat),
    .res   (res)
  );

  assign out_valid         = out_valid_r;
  assign out_stop_request  = out_res_r.stop_request;
  assign out_forward_speed = out_res_r.forward_speed;
  assign out_yaw_rate      = out_res_r.yaw_rate;

  `TFVC_ASSERT_NXT(a_hold_pc, busy_r && !go, busy_r && $stable(pc_r), "step moved while result held")
  `TFVC_ASSERT_NXT(a_emit_out, go && cw.emit, out_valid_r, "emitted result not presented")
  `TFVC_ASSERT_IMP(a_emit_tick, go && cw.emit, item_r.req_type == tfvc_pkg::REQ_TICK, "result from non-tick item")
  `TFVC_ASSERT_IMP(a_stop_zero, out_valid_r && out_stop_request, out_forward_speed == 16'sd0 && out_yaw_rate == 16'sd0, "stop with nonzero speed")

endmodule

// ===== bench/tfvc_checker.sv =====
// Checker for the target-follow controller: tracks item traffic, predicts commands, compares
`timescale 1ns / 1ps

module tfvc_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [1:0]         in_req_type,
  input  logic signed [15:0] in_bearing,
  input  logic signed [15:0] in_distance,
  input  logic [7:0]         in_robot_mode,
  input  logic [14:0]        in_forward_clearance,
  input  logic [14:0]        in_left_clearance,
  input  logic [14:0]        in_right_clearance,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic               out_stop_request,
  input  logic signed [15:0] out_forward_speed,
  input  logic signed [15:0] out_yaw_rate,
  input  logic               cfg_we,
  input  tfvc_pkg::cfg_idx_t cfg_index,
  input  logic [14:0]        cfg_wdata,
  output int                 mismatch_count,
  output int                 cmds_pending,
  output int                 cmds_checked,
  output int                 stops_seen
);

  localparam int FB               = tfvc_pkg::FRAC_BITS;
  localparam int UNIT             = 1 << FB;
  localparam int DIST_DEADBAND    = ((15 << FB) + 50) / 100;
  localparam int BEAR_DEADBAND    = ((5 << FB) + 50) / 100;
  localparam int FWD_FLOOR        = -(((3 << FB) + 5) / 10);
  localparam int FWD_SLEW         = ((75 << FB) + 500) / 1000;
  localparam int YAW_SLEW         = ((15 << FB) + 50) / 100;
  localparam int FWD_OUT_DEADBAND = ((8 << FB) + 50) / 100;
  localparam int YAW_OUT_DEADBAND = ((10 << FB) + 50) / 100;
  localparam int SMOOTH_K         = ((4 << FB) + 5) / 10;
  localparam int OFF_AXIS_BEARING = ((4 << FB) + 5) / 10;
  localparam int OFF_AXIS_FWD     = ((1 << FB) + 5) / 10;
  localparam int AVOID_START      = ((18 << FB) + 5) / 10;
  localparam int AVOID_FULL       = ((8 << FB) + 5) / 10;
  localparam int AVOID_SPAN       = AVOID_START - AVOID_FULL;
  localparam int AGE_SAT          = (1 << tfvc_pkg::AGE_BITS_DEF) - 1;

  // register copies
  int set_distance, gain_dist, gain_yaw, fwd_max, yaw_max, safe_dist, gain_avoid, timeout_q;
  // tracked state
  int sm_bearing, sm_distance, tgt_age, mode_q, gap_front, gap_left, gap_right, lidar_age_q;
  int last_fwd, last_yaw;
  bit tgt_seen, lidar_valid;

  tfvc_pkg::res_t awaited_cmds[$];

  // round to nearest, ties upward
  function automatic longint rnd_shift(input longint v, input int sh);
    return (v + (longint'(1) << (sh - 1))) >>> sh;
  endfunction

  function automatic int fixmul(input longint a, input longint b);
    return int'(rnd_shift(a * b, FB));
  endfunction

  function automatic int clip(input int v, input int lo, input int hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic int mag(input int v);
    return v < 0 ? -v : v;
  endfunction

  function automatic int blend(input int s, input int x);
    return s + fixmul(SMOOTH_K, x - s);
  endfunction

  function automatic bit halt_mode(input int m);
    return (m >= tfvc_pkg::MODE_HALT_LO && m <= tfvc_pkg::MODE_HALT_HI) ||
           m == tfvc_pkg::MODE_RECOVER;
  endfunction

  function automatic tfvc_pkg::res_t follow_tick();
    int fwd, yaw, err, urg, side, bias, cap;
    tfvc_pkg::res_t r;
    r = '0;
    if (halt_mode(mode_q) || !tgt_seen || tgt_age > timeout_q) begin
      last_fwd = 0;
      last_yaw = 0;
      r.stop_request = 1'b1;
      return r;
    end
    err = sm_distance - set_distance;
    fwd = 0;
    if (mag(err) > DIST_DEADBAND)
      fwd = clip(fixmul(gain_dist, err), FWD_FLOOR, fwd_max);
    if (sm_distance < safe_dist && fwd > 0)
      fwd = 0;
    yaw = 0;
    if (mag(sm_bearing) > BEAR_DEADBAND)
      yaw = clip(-fixmul(gain_yaw, sm_bearing), -yaw_max, yaw_max);
    if (mag(sm_bearing) > OFF_AXIS_BEARING && fwd > OFF_AXIS_FWD)
      fwd = OFF_AXIS_FWD;
    if (lidar_valid && lidar_age_q < timeout_q && gap_front < AVOID_START && fwd > 0) begin
      urg = ((AVOID_START - gap_front) * UNIT + AVOID_SPAN / 2) / AVOID_SPAN;
      urg = clip(urg, 0, UNIT);
      side = gap_right - gap_left;
      bias = -int'(rnd_shift(longint'(gain_avoid) * urg * side, 2 * FB));
      yaw = clip(yaw + bias, -yaw_max, yaw_max);
      cap = fixmul(fwd_max, UNIT - urg);
      if (fwd > cap)
        fwd = cap;
    end
    fwd = clip(fwd, last_fwd - FWD_SLEW, last_fwd + FWD_SLEW);
    yaw = clip(yaw, last_yaw - YAW_SLEW, last_yaw + YAW_SLEW);
    if (mag(fwd) < FWD_OUT_DEADBAND)
      fwd = 0;
    if (mag(yaw) < YAW_OUT_DEADBAND)
      yaw = 0;
    last_fwd = fwd;
    last_yaw = yaw;
    r.forward_speed = fwd[15:0];
    r.yaw_rate = yaw[15:0];
    return r;
  endfunction

  task automatic restore_defaults();
    set_distance = 6144;
    gain_dist = 3277;
    gain_yaw = 10240;
    fwd_max = 3277;
    yaw_max = 4915;
    safe_dist = 2458;
    gain_avoid = 8192;
    timeout_q = 10;
    sm_bearing = 0;
    sm_distance = 0;
    tgt_age = 0;
    tgt_seen = 1'b0;
    mode_q = 0;
    gap_front = 32767;
    gap_left = 32767;
    gap_right = 32767;
    lidar_age_q = 0;
    lidar_valid = 1'b0;
    last_fwd = 0;
    last_yaw = 0;
  endtask

  task automatic write_register();
    case (cfg_index)
      tfvc_pkg::CFG_DESIRED_DISTANCE:  set_distance = cfg_wdata;
      tfvc_pkg::CFG_DISTANCE_GAIN:     gain_dist = cfg_wdata;
      tfvc_pkg::CFG_YAW_GAIN:          gain_yaw = cfg_wdata;
      tfvc_pkg::CFG_FORWARD_SPEED_MAX: fwd_max = cfg_wdata;
      tfvc_pkg::CFG_YAW_RATE_MAX:      yaw_max = cfg_wdata;
      tfvc_pkg::CFG_MIN_SAFE_DISTANCE: safe_dist = cfg_wdata;
      tfvc_pkg::CFG_AVOID_GAIN:        gain_avoid = cfg_wdata;
      tfvc_pkg::CFG_TIMEOUT_TICKS:     timeout_q = cfg_wdata[7:0];
      default: ;
    endcase
  endtask

  task automatic absorb_item();
    case (tfvc_pkg::req_t'(in_req_type))
      tfvc_pkg::REQ_TICK: begin
        awaited_cmds.push_back(follow_tick());
        if (tgt_age < AGE_SAT)
          tgt_age++;
        if (lidar_age_q < AGE_SAT)
          lidar_age_q++;
      end
      tfvc_pkg::REQ_SIGHT: begin
        if (!tgt_seen || tgt_age > timeout_q) begin
          sm_bearing = in_bearing;
          sm_distance = in_distance;
        end else begin
          sm_bearing = blend(sm_bearing, in_bearing);
          sm_distance = blend(sm_distance, in_distance);
        end
        tgt_age = 0;
        tgt_seen = 1'b1;
      end
      tfvc_pkg::REQ_MODE: mode_q = in_robot_mode;
      default: begin
        gap_front = in_forward_clearance;
        gap_left = in_left_clearance;
        gap_right = in_right_clearance;
        lidar_age_q = 0;
        lidar_valid = 1'b1;
      end
    endcase
  endtask

  task automatic check_cmd();
    tfvc_pkg::res_t want;
    cmds_checked++;
    if (out_stop_request)
      stops_seen++;
    if (awaited_cmds.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("[%0t] unexpected command: stop=%0b fwd=%0d yaw=%0d", $time,
                 out_stop_request, out_forward_speed, out_yaw_rate);
      return;
    end
    want = awaited_cmds.pop_front();
    if (want.stop_request !== out_stop_request || want.forward_speed !== out_forward_speed ||
        want.yaw_rate !== out_yaw_rate) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("[%0t] command mismatch: expected stop=%0b fwd=%0d yaw=%0d, %s",
                 $time, want.stop_request, want.forward_speed, want.yaw_rate,
                 $sformatf("got stop=%0b fwd=%0d yaw=%0d",
                           out_stop_request, out_forward_speed, out_yaw_rate));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      restore_defaults();
      awaited_cmds.delete();
      mismatch_count = 0;
      cmds_checked = 0;
      stops_seen = 0;
    end else begin
      if (out_valid && !out_stall)
        check_cmd();
      if (cfg_we)
        write_register();
      if (in_valid && !in_stall)
        absorb_item();
    end
    cmds_pending = awaited_cmds.size();
  end

endmodule

// ===== bench/tb.sv =====
// Testbench top for the target-follow velocity controller: stimulus, register settings, verdict
`timescale 1ns / 1ps

module tb;

  localparam int HALF_PERIOD = 10;
  localparam int HOLD_CYCLES = 150;
  localparam int SETTLE_CYCLES = 12;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [1:0]         in_req_type;
  logic signed [15:0] in_bearing;
  logic signed [15:0] in_distance;
  logic [7:0]         in_robot_mode;
  logic [14:0]        in_forward_clearance;
  logic [14:0]        in_left_clearance;
  logic [14:0]        in_right_clearance;
  logic               out_valid;
  logic               out_stall;
  logic               out_stop_request;
  logic signed [15:0] out_forward_speed;
  logic signed [15:0] out_yaw_rate;
  logic               cfg_we;
  tfvc_pkg::cfg_idx_t cfg_index;
  logic [14:0]        cfg_wdata;
  int                 mismatch_count;
  int                 cmds_pending;
  int                 cmds_checked;
  int                 stops_seen;

  bit allow_idle;
  bit idle_en;
  int hold_reqs;
  int holds_done;
  int kind_tally[4];

  target_follow_velocity_controller dut (.*);
  tfvc_checker checker_i (.*);

  always begin
    clk = 1'b0;
    #HALF_PERIOD;
    clk = 1'b1;
    #HALF_PERIOD;
  end

  initial begin
    #5_000_000;
    $display("target_follow_velocity_controller regression: fail");
    $finish;
  end

  // result side: random stall bursts, plus one long hold on request
  initial begin
    out_stall = 1'b0;
    holds_done = 0;
    forever begin
      @(negedge clk);
      if (holds_done != hold_reqs) begin
        out_stall = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        holds_done++;
        out_stall = 1'b0;
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
        out_stall = 1'b1;
        repeat ($urandom_range(1, 9)) @(negedge clk);
        out_stall = 1'b0;
      end
    end
  end

  function automatic logic [14:0] rand15();
    bit [31:0] r;
    r = $urandom;
    return r[14:0];
  endfunction

  // unused fields carry random noise
  function automatic tfvc_pkg::item_t noise_item(input tfvc_pkg::req_t kind);
    logic [95:0] raw;
    tfvc_pkg::item_t it;
    raw = {$urandom, $urandom, $urandom};
    it = raw[$bits(tfvc_pkg::item_t)-1:0];
    it.req_type = kind;
    return it;
  endfunction

  function automatic tfvc_pkg::item_t sight_item(input logic [15:0] b, input logic [15:0] d);
    tfvc_pkg::item_t it;
    it = noise_item(tfvc_pkg::REQ_SIGHT);
    it.bearing = b;
    it.distance = d;
    return it;
  endfunction

  function automatic tfvc_pkg::item_t mode_item(input logic [7:0] m);
    tfvc_pkg::item_t it;
    it = noise_item(tfvc_pkg::REQ_MODE);
    it.robot_mode = m;
    return it;
  endfunction

  function automatic tfvc_pkg::item_t gaps_item(input logic [14:0] f, input logic [14:0] l,
                                                input logic [14:0] r);
    tfvc_pkg::item_t it;
    it = noise_item(tfvc_pkg::REQ_GAPS);
    it.forward_clearance = f;
    it.left_clearance = l;
    it.right_clearance = r;
    return it;
  endfunction

  function automatic tfvc_pkg::item_t roll_item();
    bit [31:0] r;
    tfvc_pkg::item_t it;
    int pick;
    it = noise_item(tfvc_pkg::REQ_TICK);
    pick = $urandom_range(0, 99);
    if (pick >= 45 && pick < 75) begin
      it.req_type = tfvc_pkg::REQ_SIGHT;
      if ($urandom_range(0, 9) != 0) begin
        r = $urandom_range(0, 8192) - 4096;
        it.bearing = r[15:0];
        r = $urandom_range(0, 20000);
        it.distance = r[15:0];
      end
    end else if (pick >= 75 && pick < 85) begin
      it.req_type = tfvc_pkg::REQ_MODE;
      pick = $urandom_range(0, 19);
      if (pick < 12) begin
        r = $urandom_range(0, 4);
        it.robot_mode = r[7:0];
      end else if (pick < 16) begin
        r = $urandom_range(0, 3);
        it.robot_mode = tfvc_pkg::MODE_HALT_LO + r[7:0];
      end else if (pick < 17) begin
        it.robot_mode = tfvc_pkg::MODE_RECOVER;
      end
    end else if (pick >= 85) begin
      it.req_type = tfvc_pkg::REQ_GAPS;
      if ($urandom_range(0, 9) < 7) begin
        r = $urandom_range(0, 8000);
        it.forward_clearance = r[14:0];
      end
    end
    return it;
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic offer(input tfvc_pkg::item_t it);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    in_req_type = it.req_type;
    in_bearing = it.bearing;
    in_distance = it.distance;
    in_robot_mode = it.robot_mode;
    in_forward_clearance = it.forward_clearance;
    in_left_clearance = it.left_clearance;
    in_right_clearance = it.right_clearance;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall !== 1'b0);
    kind_tally[it.req_type]++;
    @(negedge clk);
  endtask

  task automatic settle();
    in_valid = 1'b0;
    while (cmds_pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input tfvc_pkg::cfg_idx_t idx, input logic [14:0] val);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic set_all(input logic [14:0] dd, input logic [14:0] dg, input logic [14:0] yg,
                         input logic [14:0] vmax, input logic [14:0] ymax,
                         input logic [14:0] msd, input logic [14:0] ag, input logic [7:0] to);
    write_reg(tfvc_pkg::CFG_DESIRED_DISTANCE, dd);
    write_reg(tfvc_pkg::CFG_DISTANCE_GAIN, dg);
    write_reg(tfvc_pkg::CFG_YAW_GAIN, yg);
    write_reg(tfvc_pkg::CFG_FORWARD_SPEED_MAX, vmax);
    write_reg(tfvc_pkg::CFG_YAW_RATE_MAX, ymax);
    write_reg(tfvc_pkg::CFG_MIN_SAFE_DISTANCE, msd);
    write_reg(tfvc_pkg::CFG_AVOID_GAIN, ag);
    write_reg(tfvc_pkg::CFG_TIMEOUT_TICKS, {7'd0, to});
  endtask

  task automatic random_phase(input int count);
    int k, run;
    k = 0;
    while (k < count) begin
      if (k % 30 == 0)
        idle_en = allow_idle && ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 29) == 0) begin
        run = $urandom_range(5, 14);
        repeat (run) offer(noise_item(tfvc_pkg::REQ_TICK));
        k += run;
      end else begin
        offer(roll_item());
        k++;
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_req_type = tfvc_pkg::REQ_TICK;
    in_bearing = '0;
    in_distance = '0;
    in_robot_mode = '0;
    in_forward_clearance = '0;
    in_left_clearance = '0;
    in_right_clearance = '0;
    cfg_we = 1'b0;
    cfg_index = tfvc_pkg::CFG_DESIRED_DISTANCE;
    cfg_wdata = '0;
    hold_reqs = 0;
    allow_idle = 1'b1;
    idle_en = 1'b1;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: field extremes, halt modes 5, 6, 8 and recover, avoidance to one side
    offer(noise_item(tfvc_pkg::REQ_TICK));
    offer(sight_item(16'h0000, 16'h7FFF));
    offer(noise_item(tfvc_pkg::REQ_TICK));
    offer(gaps_item(15'd0, 15'd0, 15'h7FFF));
    offer(noise_item(tfvc_pkg::REQ_TICK));
    offer(noise_item(tfvc_pkg::REQ_TICK));
    offer(sight_item(16'h8000, 16'h8000));
    offer(noise_item(tfvc_pkg::REQ_TICK));
    offer(mode_item(tfvc_pkg::MODE_HALT_LO));
    offer(noise_item(tfvc_pkg::REQ_TICK));
    offer(mode_item(tfvc_pkg::MODE_RECOVER));
    offer(noise_item(tfvc_pkg::REQ_TICK));
    offer(mode_item(tfvc_pkg::MODE_HALT_HI));
    offer(noise_item(tfvc_pkg::REQ_TICK));
    offer(mode_item(8'hFF));
    offer(noise_item(tfvc_pkg::REQ_TICK));
    offer(mode_item(8'h00));
    offer(sight_item(16'h7FFF, 16'h0000));
    offer(noise_item(tfvc_pkg::REQ_TICK));
    offer(gaps_item(15'h7FFF, 15'h7FFF, 15'd0));
    offer(noise_item(tfvc_pkg::REQ_TICK));
    offer(sight_item(16'd100, 16'd6144));
    offer(noise_item(tfvc_pkg::REQ_TICK));
    offer(mode_item(tfvc_pkg::MODE_HALT_LO + 8'd1));
    offer(noise_item(tfvc_pkg::REQ_TICK));

    // defaults, with a full drain mid-phase
    random_phase(45);
    settle();
    random_phase(45);

    // random settings; result side holds off while ticks keep coming
    settle();
    set_all(rand15(), rand15(), rand15(), rand15(), rand15(), rand15(), rand15(),
            8'($urandom_range(2, 40)));
    hold_reqs++;
    offer(sight_item(16'd300, 16'd12000));
    repeat (12) offer(noise_item(tfvc_pkg::REQ_TICK));
    random_phase(77);

    // top of every range; a long run of ticks in which the target never goes stale
    settle();
    set_all(15'h7FFF, 15'h7FFF, 15'h7FFF, 15'h7FFF, 15'h7FFF, 15'h7FFF, 15'h7FFF, 8'hFF);
    offer(mode_item(8'h00));
    offer(sight_item(16'd2000, 16'd9000));
    for (int n = 0; n < 258; n++) begin
      if (n % 50 == 0)
        offer(gaps_item(15'd1000, rand15(), rand15()));
      else
        offer(noise_item(tfvc_pkg::REQ_TICK));
    end
    random_phase(30);

    // bottom of every range, zero timeout
    settle();
    set_all(15'd0, 15'd0, 15'd0, 15'd0, 15'd0, 15'd0, 15'd0, 8'd0);
    random_phase(40);

    settle();
    set_all(rand15(), rand15(), rand15(), rand15(), rand15(), rand15(), rand15(), 8'd1);
    random_phase(40);

    // defaults again, no idling to the end
    settle();
    set_all(15'd6144, 15'd3277, 15'd10240, 15'd3277, 15'd4915, 15'd2458, 15'd8192, 8'd10);
    allow_idle = 1'b0;
    idle_en = 1'b0;
    random_phase(50);
    settle();

    $display("run covered %0d ticks, %0d sightings, %0d mode and %0d clearance items",
             kind_tally[tfvc_pkg::REQ_TICK], kind_tally[tfvc_pkg::REQ_SIGHT],
             kind_tally[tfvc_pkg::REQ_MODE], kind_tally[tfvc_pkg::REQ_GAPS]);
    $display("over six register settings; %0d commands compared, %0d of them stops",
             cmds_checked, stops_seen);
    if (mismatch_count == 0 && cmds_pending == 0)
      $display("target_follow_velocity_controller regression: pass");
    else
      $display("target_follow_velocity_controller regression: fail");
    $finish;
  end

endmodule
